// ===== hw/rtl/frb_pkg.sv =====
`default_nettype none

package frb_pkg;

   // storage geometry
   localparam int MAX_FRAMES  = 1024;
   localparam int MAX_LANES   = 8;
   localparam int SAMPLE_W    = 32;
   localparam int SLOT_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int COUNT_W     = $clog2(MAX_FRAMES + 1);

   // register field widths
   localparam int CHAN_W      = 4;
   localparam int CAP_W       = 11;
   localparam int WIDE_W      = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;

   // configuration port
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_COUNT = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_CAPACITY      = CSR_INDEX_W'(1);

   localparam logic [CHAN_W-1:0] CHANNEL_COUNT_RESET = CHAN_W'(2);
   localparam logic [CAP_W-1:0]  CAPACITY_RESET      = CAP_W'(1024);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // request type codes
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   typedef logic [MAX_LANES-1:0][SAMPLE_W-1:0] frame_type;
   typedef logic [MAX_LANES-1:0]               lane_mask_type;

   typedef enum logic [1:0] {
      OP_WRITE    = 2'd0,
      OP_READ     = 2'd1,
      OP_UNDERRUN = 2'd2
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type     op;
      logic [SLOT_W-1:0] slot;
      lane_mask_type  lane_mask;
      frame_type      samples;
   } cmd_type;

   // lanes in use, with out of range counts folded back into range
   function automatic lane_mask_type lane_mask(input logic [CHAN_W-1:0] chan);
      int lanes;
      lane_mask_type mask;
      lanes = int'(chan);
      if (lanes == 0) lanes = 1;
      if (lanes > MAX_LANES) lanes = MAX_LANES;
      for (int i = 0; i < MAX_LANES; i++) begin
         mask[i] = (i < lanes);
      end
      return mask;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/frb_ifs.sv =====
`default_nettype none

// request channel: write a frame or ask for one
interface frb_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [frb_pkg::SAMPLE_W-1:0]  in_sample_0;
   logic [frb_pkg::SAMPLE_W-1:0]  in_sample_1;
   logic [frb_pkg::SAMPLE_W-1:0]  in_sample_2;
   logic [frb_pkg::SAMPLE_W-1:0]  in_sample_3;
   logic [frb_pkg::SAMPLE_W-1:0]  in_sample_4;
   logic [frb_pkg::SAMPLE_W-1:0]  in_sample_5;
   logic [frb_pkg::SAMPLE_W-1:0]  in_sample_6;
   logic [frb_pkg::SAMPLE_W-1:0]  in_sample_7;

   modport source (output valid, req_type, in_sample_0, in_sample_1, in_sample_2,
                   in_sample_3, in_sample_4, in_sample_5, in_sample_6, in_sample_7,
                   input ready);
   modport sink (input valid, req_type, in_sample_0, in_sample_1, in_sample_2,
                 in_sample_3, in_sample_4, in_sample_5, in_sample_6, in_sample_7,
                 output ready);
endinterface

// response channel: one frame per read request
interface frb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          frame_valid;
   logic [frb_pkg::SAMPLE_W-1:0]  out_sample_0;
   logic [frb_pkg::SAMPLE_W-1:0]  out_sample_1;
   logic [frb_pkg::SAMPLE_W-1:0]  out_sample_2;
   logic [frb_pkg::SAMPLE_W-1:0]  out_sample_3;
   logic [frb_pkg::SAMPLE_W-1:0]  out_sample_4;
   logic [frb_pkg::SAMPLE_W-1:0]  out_sample_5;
   logic [frb_pkg::SAMPLE_W-1:0]  out_sample_6;
   logic [frb_pkg::SAMPLE_W-1:0]  out_sample_7;

   modport source (output valid, frame_valid, out_sample_0, out_sample_1, out_sample_2,
                   out_sample_3, out_sample_4, out_sample_5, out_sample_6, out_sample_7,
                   input ready);
   modport sink (input valid, frame_valid, out_sample_0, out_sample_1, out_sample_2,
                 out_sample_3, out_sample_4, out_sample_5, out_sample_6, out_sample_7,
                 output ready);
endinterface

// register write channel
interface frb_csr_if;
   logic                             valid;
   logic                             ready;
   logic [frb_pkg::CSR_INDEX_W-1:0]  index;
   logic [frb_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/frb_front.sv =====
`default_nettype none

module frb_front (
   input  wire logic          clock,
   input  wire logic          reset,
   frb_req_if.sink            req_chan,
   frb_csr_if.sink            csr_chan,
   input  wire logic          queue_full,
   output frb_pkg::cmd_type   cmd,
   output logic               cmd_push
);

   logic [frb_pkg::CHAN_W-1:0]  channel_count_ff;
   logic [frb_pkg::CAP_W-1:0]   capacity_ff;
   logic [frb_pkg::SLOT_W-1:0]  write_slot_ff, write_slot_in;
   logic [frb_pkg::SLOT_W-1:0]  read_slot_ff, read_slot_in;
   logic [frb_pkg::COUNT_W-1:0] held_ff, held_in;

   logic [frb_pkg::WIDE_W-1:0]  cap_wide;
   logic [frb_pkg::COUNT_W-1:0] cap;
   logic [frb_pkg::COUNT_W-1:0] write_next, read_next;
   logic [frb_pkg::SLOT_W-1:0]  write_wrap, read_wrap;
   frb_pkg::lane_mask_type      mask;
   frb_pkg::frame_type          raw;
   logic                        accept;
   logic                        csr_write;

   assign req_chan.ready = !queue_full;
   assign csr_chan.ready = 1'b1;
   assign accept         = req_chan.valid && !queue_full;
   assign csr_write      = csr_chan.valid;

   // active capacity, folded into one to the store depth
   always_comb begin
      cap_wide = frb_pkg::WIDE_W'(capacity_ff);
      if (cap_wide == '0) begin
         cap_wide = frb_pkg::WIDE_W'(1);
      end else if (cap_wide > frb_pkg::WIDE_W'(frb_pkg::MAX_FRAMES)) begin
         cap_wide = frb_pkg::WIDE_W'(frb_pkg::MAX_FRAMES);
      end
   end
   assign cap  = cap_wide[frb_pkg::COUNT_W-1:0];
   assign mask = frb_pkg::lane_mask(channel_count_ff);

   // slot advance with wrap at the capacity
   assign write_next = frb_pkg::COUNT_W'(write_slot_ff) + frb_pkg::COUNT_W'(1);
   assign read_next  = frb_pkg::COUNT_W'(read_slot_ff) + frb_pkg::COUNT_W'(1);
   assign write_wrap = (write_next >= cap) ? '0 : write_next[frb_pkg::SLOT_W-1:0];
   assign read_wrap  = (read_next >= cap) ? '0 : read_next[frb_pkg::SLOT_W-1:0];

   assign raw[0] = req_chan.in_sample_0;
   assign raw[1] = req_chan.in_sample_1;
   assign raw[2] = req_chan.in_sample_2;
   assign raw[3] = req_chan.in_sample_3;
   assign raw[4] = req_chan.in_sample_4;
   assign raw[5] = req_chan.in_sample_5;
   assign raw[6] = req_chan.in_sample_6;
   assign raw[7] = req_chan.in_sample_7;

   // classify the request and build the command
   always_comb begin
      write_slot_in = write_slot_ff;
      read_slot_in  = read_slot_ff;
      held_in       = held_ff;
      cmd.lane_mask = mask;
      cmd.slot      = write_slot_ff;
      cmd.op        = frb_pkg::OP_WRITE;
      for (int i = 0; i < frb_pkg::MAX_LANES; i++) begin
         cmd.samples[i] = mask[i] ? raw[i] : '0;
      end
      if (req_chan.req_type == frb_pkg::REQ_WRITE) begin
         write_slot_in = write_wrap;
         if (held_ff >= cap - frb_pkg::COUNT_W'(1)) begin
            // full: the oldest frame goes
            held_in      = cap;
            read_slot_in = write_wrap;
         end else begin
            held_in = held_ff + frb_pkg::COUNT_W'(1);
         end
      end else if (held_ff == '0) begin
         cmd.op = frb_pkg::OP_UNDERRUN;
      end else begin
         cmd.op       = frb_pkg::OP_READ;
         cmd.slot     = read_slot_ff;
         read_slot_in = read_wrap;
         held_in      = held_ff - frb_pkg::COUNT_W'(1);
      end
   end

   assign cmd_push = accept;

   // configuration registers and ring pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= frb_pkg::CHANNEL_COUNT_RESET;
         capacity_ff      <= frb_pkg::CAPACITY_RESET;
         write_slot_ff    <= '0;
         read_slot_ff     <= '0;
         held_ff          <= '0;
      end else begin
         if (accept) begin
            write_slot_ff <= write_slot_in;
            read_slot_ff  <= read_slot_in;
            held_ff       <= held_in;
         end
         if (csr_write) begin
            case (csr_chan.index)
               frb_pkg::REG_CHANNEL_COUNT: begin
                  channel_count_ff <= csr_chan.data[frb_pkg::CHAN_W-1:0];
               end
               frb_pkg::REG_CAPACITY: begin
                  capacity_ff   <= csr_chan.data[frb_pkg::CAP_W-1:0];
                  write_slot_ff <= '0;
                  read_slot_ff  <= '0;
                  held_ff       <= '0;
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/frb_queue.sv =====
`default_nettype none

module frb_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire frb_pkg::cmd_type   push_cmd,
   output logic                    full,
   input  wire logic               pop,
   output frb_pkg::cmd_type        head_cmd,
   output logic                    empty
);

   frb_pkg::cmd_type               entry_ff [frb_pkg::QUEUE_DEPTH];
   logic [frb_pkg::QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [frb_pkg::QCOUNT_W-1:0]   count_ff;

   assign full     = (count_ff == frb_pkg::QCOUNT_W'(frb_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == frb_pkg::QPTR_W'(frb_pkg::QUEUE_DEPTH - 1))
                         ? '0 : wr_ptr_ff + frb_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == frb_pkg::QPTR_W'(frb_pkg::QUEUE_DEPTH - 1))
                         ? '0 : rd_ptr_ff + frb_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + frb_pkg::QCOUNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - frb_pkg::QCOUNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/frb_back.sv =====
`default_nettype none

module frb_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire frb_pkg::cmd_type   head_cmd,
   input  wire logic               empty,
   output logic                    pop,
   frb_rsp_if.source               rsp_chan
);

   frb_pkg::frame_type      store [frb_pkg::MAX_FRAMES];
   frb_pkg::frame_type      rd_data_ff;
   frb_pkg::lane_mask_type  rd_mask_ff;
   logic                    rd_pend_ff;

   logic                    rsp_valid_ff;
   logic                    frame_valid_ff;
   frb_pkg::frame_type      samples_ff;

   logic                    out_free;
   logic                    do_write, do_read, do_underrun;

   // pick up the head command when its resources are free
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign do_write    = !empty && (head_cmd.op == frb_pkg::OP_WRITE);
   assign do_read     = !empty && (head_cmd.op == frb_pkg::OP_READ)
                        && !rd_pend_ff && out_free;
   assign do_underrun = !empty && (head_cmd.op == frb_pkg::OP_UNDERRUN)
                        && !rd_pend_ff && out_free;
   assign pop         = do_write || do_read || do_underrun;

   // frame store, one access a cycle
   always_ff @(posedge clock) begin
      if (do_write) begin
         store[head_cmd.slot] <= head_cmd.samples;
      end
      if (do_read) begin
         rd_data_ff <= store[head_cmd.slot];
         rd_mask_ff <= head_cmd.lane_mask;
      end
   end

   // read in flight flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= do_read;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rd_pend_ff || do_underrun) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         frame_valid_ff <= 1'b1;
         for (int i = 0; i < frb_pkg::MAX_LANES; i++) begin
            samples_ff[i] <= rd_mask_ff[i] ? rd_data_ff[i] : '0;
         end
      end else if (do_underrun) begin
         frame_valid_ff <= 1'b0;
         samples_ff     <= '0;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.frame_valid  = frame_valid_ff;
   assign rsp_chan.out_sample_0 = samples_ff[0];
   assign rsp_chan.out_sample_1 = samples_ff[1];
   assign rsp_chan.out_sample_2 = samples_ff[2];
   assign rsp_chan.out_sample_3 = samples_ff[3];
   assign rsp_chan.out_sample_4 = samples_ff[4];
   assign rsp_chan.out_sample_5 = samples_ff[5];
   assign rsp_chan.out_sample_6 = samples_ff[6];
   assign rsp_chan.out_sample_7 = samples_ff[7];

endmodule

`default_nettype wire

// ===== hw/rtl/frame_ring_buffer_drop_oldest.sv =====
`default_nettype none

// Ring buffer of audio frames (up to eight 32-bit lanes) that overwrites the
// oldest frame when full. A write request stores a frame and gives no response;
// a read request gives one response with the oldest frame and frame_valid set,
// or zeros with frame_valid clear when empty. Lanes above channel_count are
// stored and returned as zero. Writing capacity_in_frames empties the buffer.
// Requests are taken one per cycle while the two-entry command queue has room,
// and the pointer update is done at acceptance. Behind the queue the frame store
// (one port, 1024 x 256 bits) does one access a cycle. Writes retire at one per
// cycle, underruns at one per cycle while responses are taken. A read that hits
// a held frame holds off the next read or underrun until its store read has moved
// on to the response register. A read response goes from the store read register
// to the response register, an underrun straight into the response register; a
// stalled response holds the back part, and a full queue stalls the input.
module frame_ring_buffer_drop_oldest (
   input  wire logic  clock,
   input  wire logic  reset,
   frb_req_if.sink    req_chan,
   frb_rsp_if.source  rsp_chan,
   frb_csr_if.sink    csr_chan
);

   frb_pkg::cmd_type  push_cmd;
   frb_pkg::cmd_type  head_cmd;
   logic              push;
   logic              pop;
   logic              full;
   logic              empty;

   // request classification and ring pointers
   frb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .queue_full (full),
      .cmd        (push_cmd),
      .cmd_push   (push)
   );

   // command queue
   frb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (empty)
   );

   // frame store and response
   frb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .empty    (empty),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== sim/frb_readback_check.sv =====
`default_nettype none

module frb_readback_check
   import frb_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   frb_req_if          req_mon,
   frb_rsp_if          rsp_mon,
   frb_csr_if          csr_mon,
   output int unsigned mismatch_count,
   output int unsigned frames_due
);
   timeunit 1ns;
   timeprecision 1ps;

   // one expected read response
   typedef struct packed {
      logic      frame_valid;
      frame_type samples;
   } readback_type;

   // shadow of the ring and its registers
   frame_type         slot_frames [MAX_FRAMES];
   int                wr_slot;
   int                rd_slot;
   int                held;
   logic [CHAN_W-1:0] lane_reg;
   logic [CAP_W-1:0]  cap_reg;
   readback_type      due_frames [$];

   frame_type         in_frame;
   readback_type      out_frame;

   initial begin
      mismatch_count = 0;
      frames_due     = 0;
   end

   // lane count folded into 1..MAX_LANES
   function automatic int active_lanes();
      if (lane_reg == 0) return 1;
      if (int'(lane_reg) > MAX_LANES) return MAX_LANES;
      return int'(lane_reg);
   endfunction

   // capacity folded into 1..MAX_FRAMES
   function automatic int active_slots();
      if (cap_reg == 0) return 1;
      if (int'(cap_reg) > MAX_FRAMES) return MAX_FRAMES;
      return int'(cap_reg);
   endfunction

   // advance the shadow ring by one accepted request
   task automatic model_request(input logic kind, input frame_type frame);
      int           cap;
      int           lanes;
      frame_type    kept;
      readback_type rb;
      cap   = active_slots();
      lanes = active_lanes();
      if (wr_slot >= cap) wr_slot = 0;
      if (rd_slot >= cap) rd_slot = 0;
      if (held > cap) held = cap;
      if (kind == REQ_WRITE) begin
         // unused lanes are stored as zero
         kept = '0;
         for (int l = 0; l < lanes; l++) kept[l] = frame[l];
         slot_frames[wr_slot] = kept;
         wr_slot = (wr_slot + 1 >= cap) ? 0 : wr_slot + 1;
         held++;
         // full: the oldest frame is dropped
         if (held >= cap) begin
            held    = cap;
            rd_slot = wr_slot;
         end
      end else if (held == 0) begin
         // underrun returns zeros with the flag clear
         due_frames.push_back('0);
      end else begin
         rb.frame_valid = 1'b1;
         rb.samples     = '0;
         for (int l = 0; l < lanes; l++) rb.samples[l] = slot_frames[rd_slot][l];
         due_frames.push_back(rb);
         rd_slot = (rd_slot + 1 >= cap) ? 0 : rd_slot + 1;
         held--;
      end
   endtask

   // compare one response against the oldest expectation
   task automatic check_readback(input readback_type got);
      readback_type want;
      if (due_frames.size() == 0) begin
         mismatch_count++;
         $display("%0t: response with none expected: frame_valid %0b", $time,
                  got.frame_valid);
      end else begin
         want = due_frames.pop_front();
         if (got.frame_valid !== want.frame_valid) begin
            mismatch_count++;
            $display("%0t: frame_valid expected %0b actual %0b", $time,
                     want.frame_valid, got.frame_valid);
         end
         for (int l = 0; l < MAX_LANES; l++) begin
            if (got.samples[l] !== want.samples[l]) begin
               mismatch_count++;
               $display("%0t: out_sample_%0d expected %h actual %h", $time, l,
                        want.samples[l], got.samples[l]);
            end
         end
      end
   endtask

   // watch all three channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         wr_slot  = 0;
         rd_slot  = 0;
         held     = 0;
         lane_reg = CHANNEL_COUNT_RESET;
         cap_reg  = CAPACITY_RESET;
         due_frames.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            out_frame.frame_valid = rsp_mon.frame_valid;
            out_frame.samples     = {rsp_mon.out_sample_7, rsp_mon.out_sample_6,
                                     rsp_mon.out_sample_5, rsp_mon.out_sample_4,
                                     rsp_mon.out_sample_3, rsp_mon.out_sample_2,
                                     rsp_mon.out_sample_1, rsp_mon.out_sample_0};
            check_readback(out_frame);
         end
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == REG_CHANNEL_COUNT) begin
               lane_reg = csr_mon.data[CHAN_W-1:0];
            end else if (csr_mon.index == REG_CAPACITY) begin
               // new capacity empties the ring
               cap_reg = csr_mon.data[CAP_W-1:0];
               wr_slot = 0;
               rd_slot = 0;
               held    = 0;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            in_frame = {req_mon.in_sample_7, req_mon.in_sample_6, req_mon.in_sample_5,
                        req_mon.in_sample_4, req_mon.in_sample_3, req_mon.in_sample_2,
                        req_mon.in_sample_1, req_mon.in_sample_0};
            model_request(req_mon.req_type, in_frame);
         end
      end
      frames_due = due_frames.size();
   end

endmodule

`default_nettype wire

// ===== sim/tb_frame_ring_buffer_drop_oldest.sv =====
`default_nettype none

module tb_frame_ring_buffer_drop_oldest;
   timeunit 1ns;
   timeprecision 1ps;
   import frb_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_PCT      = 18;

   // register indexes the block does not decode
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LOW  = REG_CAPACITY + 1'b1;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HIGH = '1;

   logic        clock;
   logic        reset;
   logic        steady;
   int unsigned cycle_count;
   int unsigned mismatch_count;
   int unsigned frames_due;

   frb_req_if req_chan ();
   frb_rsp_if rsp_chan ();
   frb_csr_if csr_chan ();

   frame_ring_buffer_drop_oldest i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   frb_readback_check i_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_mon        (csr_chan),
      .mismatch_count (mismatch_count),
      .frames_due     (frames_due)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("frame_ring_buffer_drop_oldest verification failed");
         $finish;
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      rsp_chan.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   function automatic frame_type random_frame();
      frame_type frame;
      for (int l = 0; l < MAX_LANES; l++) frame[l] = $urandom;
      return frame;
   endfunction

   // present one request, with a random gap first, and wait for it to be taken
   task automatic send_frame(input logic kind, input frame_type frame);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.req_type    <= kind;
      req_chan.in_sample_0 <= frame[0];
      req_chan.in_sample_1 <= frame[1];
      req_chan.in_sample_2 <= frame[2];
      req_chan.in_sample_3 <= frame[3];
      req_chan.in_sample_4 <= frame[4];
      req_chan.in_sample_5 <= frame[5];
      req_chan.in_sample_6 <= frame[6];
      req_chan.in_sample_7 <= frame[7];
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // stop sending, let every response arrive and trailing writes retire
   task automatic settle();
      req_chan.valid <= 1'b0;
      wait (frames_due == 0);
      @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_register(input logic [CSR_INDEX_W-1:0] index,
                                   input logic [CSR_DATA_W-1:0]  value);
      settle();
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // lane count and, if set_cap, capacity, then a random mix of writes and reads
   task automatic run_phase(input logic [CSR_DATA_W-1:0] lane_value,
                            input logic [CSR_DATA_W-1:0] cap_value,
                            input bit set_cap, input int count,
                            input int write_pct, input bit calm);
      program_register(REG_CHANNEL_COUNT, lane_value);
      if (set_cap) program_register(REG_CAPACITY, cap_value);
      steady <= calm;
      for (int k = 0; k < count; k++) begin
         send_frame(($urandom_range(99) < write_pct) ? REQ_WRITE : REQ_READ,
                    random_frame());
      end
   endtask

   initial begin
      reset                = 1'b1;
      steady               = 1'b0;
      req_chan.valid       = 1'b0;
      req_chan.req_type    = REQ_WRITE;
      req_chan.in_sample_0 = '0;
      req_chan.in_sample_1 = '0;
      req_chan.in_sample_2 = '0;
      req_chan.in_sample_3 = '0;
      req_chan.in_sample_4 = '0;
      req_chan.in_sample_5 = '0;
      req_chan.in_sample_6 = '0;
      req_chan.in_sample_7 = '0;
      rsp_chan.ready       = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.index       = REG_CHANNEL_COUNT;
      csr_chan.data        = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // reset settings: underrun, then frames whose upper lanes must drop
      send_frame(REQ_READ, '1);
      send_frame(REQ_WRITE, '1);
      send_frame(REQ_WRITE, '0);
      send_frame(REQ_WRITE, {MAX_LANES{32'hAAAA_AAAA}});
      send_frame(REQ_WRITE, {MAX_LANES{32'h5555_5555}});
      repeat (5) send_frame(REQ_READ, '0);

      // all lanes, two slots: overflow drops the oldest
      program_register(REG_CHANNEL_COUNT, CSR_DATA_W'(MAX_LANES));
      program_register(REG_CAPACITY, CSR_DATA_W'(2));
      send_frame(REQ_WRITE, '1);
      send_frame(REQ_WRITE, {MAX_LANES{32'hAAAA_AAAA}});
      send_frame(REQ_WRITE, {MAX_LANES{32'h5555_5555}});
      repeat (3) send_frame(REQ_READ, '1);
      send_frame(REQ_WRITE, '0);
      send_frame(REQ_READ, '0);

      // random phases across the register ranges, out of range values too
      run_phase(8, 4, 1'b1, 60, 55, 1'b0);
      run_phase(1, 1, 1'b1, 50, 50, 1'b0);
      run_phase(0, 3, 1'b1, 50, 60, 1'b0);
      run_phase(15, 0, 1'b1, 40, 50, 1'b0);
      run_phase(5, 1024, 1'b1, 60, 60, 1'b1);
      // lane count change with frames still held
      run_phase(3, 0, 1'b0, 40, 40, 1'b0);
      run_phase(9, 2047, 1'b1, 50, 50, 1'b0);
      run_phase(6, 2, 1'b1, 50, 50, 1'b0);
      run_phase(8, 16, 1'b1, 60, 70, 1'b0);
      run_phase(2, 7, 1'b1, 50, 35, 1'b0);
      // undecoded indexes must change nothing
      program_register(REG_SPARE_LOW, '1);
      program_register(REG_SPARE_HIGH, '1);
      run_phase(8, 5, 1'b1, 40, 50, 1'b0);

      settle();
      if (mismatch_count == 0) begin
         $display("frame_ring_buffer_drop_oldest verification clean");
      end else begin
         $display("frame_ring_buffer_drop_oldest verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
